>>> hdl/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

  // Default receive buffer depth in bytes
  localparam int BUFFER_DEPTH_DEF = 64;

  // Longest length byte value ever accepted
  localparam logic [7:0] LEN_LIMIT = 8'h24;

  // Index over one frame: offsets 0 .. LEN_LIMIT + 1
  localparam int IDX_W = 6;

  // Register reset values
  localparam logic [5:0] LENGTH_MIN_RST     = 6'h03;
  localparam logic [5:0] LENGTH_MAX_RST     = 6'h24;
  localparam logic [7:0] GAP_TIMEOUT_RST    = 8'd8;
  localparam logic [7:0] SEND_GAP_RST       = 8'd5;

  localparam logic [7:0]  IDLE_MS_MAX = 8'hFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LENGTH_MIN  = 2'd0,
    REG_LENGTH_MAX  = 2'd1,
    REG_GAP_TIMEOUT = 2'd2,
    REG_SEND_GAP    = 2'd3
  } cfg_idx_t;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

endpackage

`default_nettype wire

>>> hdl/bfr_if.sv
`default_nettype none

// Input channel: received byte or millisecond tick
interface bfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// Output channel: frame bytes and status reports
interface bfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic [15:0] frames_good;
  logic [15:0] checksum_errors;
  logic        clear_to_send;

  modport source (output valid, output kind, output frame_byte, output last_byte,
                  output frames_good, output checksum_errors, output clear_to_send,
                  input ready);
  modport sink   (input valid, input kind, input frame_byte, input last_byte,
                  input frames_good, input checksum_errors, input clear_to_send,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/bfr_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bus_frame_receiver_core.sv
// Tick: S_STAT loads the status result once the output slot is free, then input is taken again.
// Byte: a scan passes S_SCAN and S_LEN per dropped byte and adds S_SUM per checksum walk,
// one RAM read per cycle, one item at a time; frame bytes leave via S_EMIT_RD, then S_EMIT_WR.
// A byte that ends no frame frees the input after S_SCAN or S_LEN, plus any drops and walks above.
// Reset (synchronous, active high) empties the buffer and clears the counters and the
// idle time; the buffer RAM is not cleared, only entries already written are read.
`default_nettype none

module bus_frame_receiver_core #(
  parameter int BUFFER_DEPTH = bfr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  bfr_in_if.sink                 in_ch,
  bfr_out_if.source              out_ch,
  input  wire logic              cfg_write,
  input  wire bfr_pkg::cfg_idx_t cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import bfr_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(BUFFER_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_STAT    = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_LEN     = 7'b0001000,
    S_SUM     = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_WR = 7'b1000000
  } state_t;

  // Circular pointer advance, offset never above the depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W:0]   off);
    logic [PTR_W:0] sum;
    sum = {1'b0, p} + off;
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[PTR_W-1:0];
  endfunction

  // Configuration registers
  logic [5:0] length_min;
  logic [5:0] length_max;
  logic [7:0] gap_timeout_ms;
  logic [7:0] send_gap_ms;

  // Control state
  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [7:0]       idle_ms, idle_ms_next;
  logic [15:0]      good_count, good_count_next;
  logic [15:0]      error_count, error_count_next;
  logic [IDX_W-1:0] len_q, len_q_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             rd_valid, rd_valid_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [7:0]       xsum, xsum_next;

  // Output register
  logic        out_valid;
  logic        out_load;
  logic        out_kind, out_kind_next;
  logic [7:0]  out_byte, out_byte_next;
  logic        out_last, out_last_next;
  logic [15:0] out_good, out_good_next;
  logic [15:0] out_errs, out_errs_next;
  logic        out_cts, out_cts_next;

  // RAM port signals
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  logic             slot_free;
  logic             in_take;
  logic [7:0]       idle_inc;
  logic [IDX_W-1:0] chk_idx;
  logic [IDX_W-1:0] need;
  logic             len_bad;

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_ch.rx_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign slot_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign in_take = in_ch.valid && in_ch.ready;
  assign idle_inc = (idle_ms == IDLE_MS_MAX) ? idle_ms : idle_ms + 8'd1;
  assign chk_idx = IDX_W'(len_q + IDX_W'(1));
  assign need = IDX_W'(len_q + IDX_W'(2));
  assign len_bad = (ram_rdata < {2'b00, length_min}) || (ram_rdata > {2'b00, length_max})
                   || (ram_rdata > LEN_LIMIT);

  // Sequencer
  always_comb begin
    state_next       = state;
    head_next        = head;
    fill_next        = fill;
    idle_ms_next     = idle_ms;
    good_count_next  = good_count;
    error_count_next = error_count;
    len_q_next       = len_q;
    idx_next         = idx;
    rd_valid_next    = 1'b0;
    rd_idx_next      = rd_idx;
    xsum_next        = xsum;
    ram_we           = 1'b0;
    ram_waddr        = ptr_add(head, (PTR_W + 1)'(fill));
    ram_re           = 1'b0;
    ram_raddr        = ptr_add(head, (PTR_W + 1)'(idx));
    out_load         = 1'b0;
    out_kind_next    = KIND_FRAME;
    out_byte_next    = ram_rdata;
    out_last_next    = (idx == chk_idx);
    out_good_next    = '0;
    out_errs_next    = '0;
    out_cts_next     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_ch.op == OP_BYTE) begin
            idle_ms_next = '0;
            ram_we = 1'b1;
            if (fill == FILL_FULL) begin
              // full: overwrite the oldest byte
              ram_waddr = head;
              head_next = ptr_add(head, (PTR_W + 1)'(1));
            end else begin
              fill_next = fill + CNT_W'(1);
            end
            state_next = S_SCAN;
          end else begin
            idle_ms_next = idle_inc;
            if (fill != '0 && idle_inc >= gap_timeout_ms) begin
              fill_next = '0;
            end
            state_next = S_STAT;
          end
        end
      end

      S_STAT: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_kind_next = KIND_STATUS;
          out_byte_next = '0;
          out_last_next = 1'b0;
          out_good_next = good_count;
          out_errs_next = error_count;
          out_cts_next  = (idle_ms >= send_gap_ms);
          state_next    = S_IDLE;
        end
      end

      S_SCAN: begin
        if (fill < CNT_W'(2)) begin
          state_next = S_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = ptr_add(head, (PTR_W + 1)'(1));
          state_next = S_LEN;
        end
      end

      S_LEN: begin
        if (len_bad) begin
          head_next  = ptr_add(head, (PTR_W + 1)'(1));
          fill_next  = fill - CNT_W'(1);
          state_next = S_SCAN;
        end else if (fill < CNT_W'(ram_rdata + 8'd2)) begin
          state_next = S_IDLE;
        end else begin
          len_q_next = ram_rdata[IDX_W-1:0];
          idx_next   = '0;
          xsum_next  = '0;
          state_next = S_SUM;
        end
      end

      S_SUM: begin
        // reads issued one per cycle, data folded in on the cycle after
        if (idx <= chk_idx) begin
          ram_re        = 1'b1;
          idx_next      = idx + IDX_W'(1);
          rd_valid_next = 1'b1;
          rd_idx_next   = idx;
        end
        if (rd_valid) begin
          if (rd_idx == chk_idx) begin
            if (ram_rdata == xsum) begin
              idx_next   = '0;
              state_next = S_EMIT_RD;
            end else begin
              if (error_count != COUNT_MAX) begin
                error_count_next = error_count + 16'd1;
              end
              head_next  = ptr_add(head, (PTR_W + 1)'(1));
              fill_next  = fill - CNT_W'(1);
              state_next = S_SCAN;
            end
          end else begin
            xsum_next = xsum ^ ram_rdata;
          end
        end
      end

      S_EMIT_RD: begin
        ram_re     = 1'b1;
        state_next = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (idx == chk_idx) begin
            if (good_count != COUNT_MAX) begin
              good_count_next = good_count + 16'd1;
            end
            head_next  = ptr_add(head, (PTR_W + 1)'(need));
            fill_next  = fill - CNT_W'(need);
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      fill        <= '0;
      idle_ms     <= '0;
      good_count  <= '0;
      error_count <= '0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      fill        <= fill_next;
      idle_ms     <= idle_ms_next;
      good_count  <= good_count_next;
      error_count <= error_count_next;
      rd_valid    <= rd_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    len_q  <= len_q_next;
    idx    <= idx_next;
    rd_idx <= rd_idx_next;
    xsum   <= xsum_next;
    if (out_load) begin
      out_kind <= out_kind_next;
      out_byte <= out_byte_next;
      out_last <= out_last_next;
      out_good <= out_good_next;
      out_errs <= out_errs_next;
      out_cts  <= out_cts_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      length_min     <= LENGTH_MIN_RST;
      length_max     <= LENGTH_MAX_RST;
      gap_timeout_ms <= GAP_TIMEOUT_RST;
      send_gap_ms    <= SEND_GAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LENGTH_MIN:  length_min     <= cfg_data[5:0];
        REG_LENGTH_MAX:  length_max     <= cfg_data[5:0];
        REG_GAP_TIMEOUT: gap_timeout_ms <= cfg_data;
        REG_SEND_GAP:    send_gap_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.kind            = out_kind;
  assign out_ch.frame_byte      = out_byte;
  assign out_ch.last_byte       = out_last;
  assign out_ch.frames_good     = out_good;
  assign out_ch.checksum_errors = out_errs;
  assign out_ch.clear_to_send   = out_cts;

  // Buffer never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("receive buffer fill above depth");

  // Status transactions carry no frame byte
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_STATUS) |-> (out_byte == '0 && !out_last))
    else $error("status result carries frame data");

  // Counters never go down
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (good_count >= $past(good_count) && error_count >= $past(error_count)))
    else $error("counter went down");

  // A frame byte is loaded only with a frame emission under way
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_kind_next == KIND_FRAME) |-> (state == S_EMIT_WR))
    else $error("frame byte loaded outside emission");

  // A received byte always starts a scan
  a_byte_scan: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_ch.op == OP_BYTE) |=> (state == S_SCAN))
    else $error("byte accepted without scan");

endmodule

`default_nettype wire

>>> verif/tb_bus_frame_receiver_core.sv
module tb_bus_frame_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  // covers the worst rescan of a byte that ends no frame, with its dropped bytes and checksum walks
  localparam int SETTLE_CYCLES  = 2000;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic        kind;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [15:0] frames_good;
    logic [15:0] checksum_errors;
    logic        clear_to_send;
  } bus_result_t;

  // Frame parser predictor and result scoreboard
  class frame_scoreboard;
    logic [7:0]  rx_fifo[$];
    int unsigned idle_ms;
    int unsigned good_frames;
    int unsigned crc_errors;
    int unsigned len_min;
    int unsigned len_max;
    int unsigned gap_timeout;
    int unsigned send_gap;
    bus_result_t pending[$];
    int unsigned mismatches;
    int unsigned byte_results;
    int unsigned status_results;

    function new();
      len_min     = LENGTH_MIN_RST;
      len_max     = LENGTH_MAX_RST;
      gap_timeout = GAP_TIMEOUT_RST;
      send_gap    = SEND_GAP_RST;
    endfunction

    function void set_register(cfg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_LENGTH_MIN:  len_min = val[5:0];
        REG_LENGTH_MAX:  len_max = val[5:0];
        REG_GAP_TIMEOUT: gap_timeout = val;
        REG_SEND_GAP:    send_gap = val;
        default: ;
      endcase
    endfunction

    // Scan the buffer until it stalls or one good frame has gone out
    function void scan_fifo();
      int unsigned len;
      logic [7:0]  sum;
      bus_result_t r;
      forever begin
        if (rx_fifo.size() < 2) return;
        len = rx_fifo[1];
        if (len < len_min || len > len_max || len > LEN_LIMIT) begin
          void'(rx_fifo.pop_front());
          continue;
        end
        if (rx_fifo.size() < len + 2) return;
        sum = 8'h00;
        for (int i = 0; i <= len; i++) sum ^= rx_fifo[i];
        if (rx_fifo[len + 1] == sum) begin
          for (int i = 0; i < len + 2; i++) begin
            r = '0;
            r.kind       = KIND_FRAME;
            r.frame_byte = rx_fifo[i];
            r.last_byte  = (i == len + 1);
            pending.push_back(r);
          end
          if (good_frames < COUNT_MAX) good_frames++;
          for (int i = 0; i < len + 2; i++) void'(rx_fifo.pop_front());
          return;
        end
        if (crc_errors < COUNT_MAX) crc_errors++;
        void'(rx_fifo.pop_front());
      end
    endfunction

    function void note_item(logic op, logic [7:0] data);
      bus_result_t r;
      if (op == OP_BYTE) begin
        idle_ms = 0;
        if (rx_fifo.size() >= BUFFER_DEPTH_DEF) void'(rx_fifo.pop_front());
        rx_fifo.push_back(data);
        scan_fifo();
      end else begin
        if (idle_ms < IDLE_MS_MAX) idle_ms++;
        if (rx_fifo.size() > 0 && idle_ms >= gap_timeout) rx_fifo.delete();
        r = '0;
        r.kind            = KIND_STATUS;
        r.frames_good     = 16'(good_frames);
        r.checksum_errors = 16'(crc_errors);
        r.clear_to_send   = (idle_ms >= send_gap);
        pending.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(bus_result_t act);
      bus_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, act);
        return;
      end
      e = pending.pop_front();
      if (e.kind == KIND_FRAME) byte_results++;
      else status_results++;
      compare_field("kind", e.kind, act.kind);
      compare_field("frame_byte", e.frame_byte, act.frame_byte);
      compare_field("last_byte", e.last_byte, act.last_byte);
      compare_field("frames_good", e.frames_good, act.frames_good);
      compare_field("checksum_errors", e.checksum_errors, act.checksum_errors);
      compare_field("clear_to_send", e.clear_to_send, act.clear_to_send);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_write;
  cfg_idx_t   cfg_index;
  logic [7:0] cfg_data;

  bfr_in_if  in_ch();
  bfr_out_if out_ch();

  frame_scoreboard sb;
  bus_result_t     seen;
  int unsigned     items_sent;
  int unsigned     settings_used;
  int unsigned     quiet_cycles;
  int unsigned     stall_left;
  int unsigned     idle_pct;

  bus_frame_receiver_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_LENGTH_MIN;
    cfg_data       = 8'h00;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_BYTE;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    stall_left     = 0;
    idle_pct       = 20;
    sb             = new();
  end

  // Sink side: ready drops in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 199) < idle_pct) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitors: feed the predictor and check results
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_item(in_ch.op, in_ch.rx_byte);
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.kind, out_ch.frame_byte, out_ch.last_byte, out_ch.frames_good,
               out_ch.checksum_errors, out_ch.clear_to_send};
      sb.check_result(seen);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item; called and returns at a falling edge
  task automatic send_item(input logic op, input logic [7:0] data);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= data;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold off input until every result is out and the block has gone quiet
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] lmin, input logic [7:0] lmax,
                                input logic [7:0] gap, input logic [7:0] send);
    logic [7:0] vals[4];
    vals = '{lmin, lmax, gap, send};
    settle_block();
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_register(cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Well-formed frame of the given length, optionally with a corrupted checksum and stray ticks
  task automatic send_frame(input int unsigned len, input bit corrupt);
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    if (len == 0) begin
      // checksum of the source alone sits in the length slot
      frame_q = '{8'h00, 8'h00};
    end else begin
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'(len));
      repeat (len - 1) frame_q.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      foreach (frame_q[i]) sum ^= frame_q[i];
      frame_q.push_back(sum);
    end
    if (corrupt) frame_q[frame_q.size() - 1] ^= 8'($urandom_range(1, 255));
    foreach (frame_q[i]) begin
      if (i > 0 && $urandom_range(0, 19) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      send_item(OP_BYTE, frame_q[i]);
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned lo;
    int unsigned hi;
    lo = sb.len_min;
    hi = (sb.len_max > LEN_LIMIT) ? LEN_LIMIT : sb.len_max;
    if ($urandom_range(0, 4) != 0 && hi > lo + 8) hi = lo + 8;
    return $urandom_range(lo, hi);
  endfunction

  // Mostly valid frames, with noise bytes, ticks and cut-off frames mixed in
  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && sb.len_min <= sb.len_max && sb.len_min <= LEN_LIMIT) begin
        send_frame(pick_length(), $urandom_range(0, 4) == 0);
      end else if (pick < 75) begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        send_item(OP_BYTE, 8'($urandom_range(sb.len_min, LEN_LIMIT)));
        repeat ($urandom_range(1, 10)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    items_sent    = 0;
    settings_used = 1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults, good and bad frames, bad lengths, gap timeout
    send_item(OP_TICK, 8'hFF);
    send_frame(3, 1'b0);
    send_frame(3, 1'b1);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h25);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h04);
    repeat (8) send_item(OP_TICK, 8'h00);
    random_traffic(20);

    // Short lengths including 0 to 2, two ticks in a row clear a partial frame
    apply_settings(8'd0, 8'd3, 8'd2, 8'd1);
    random_traffic(14);

    // Empty length window: every byte is dropped; no idling in this stretch
    idle_pct = 0;
    apply_settings(8'd20, 8'd10, 8'd4, 8'd3);
    random_traffic(8);

    // Longest frames only, slowest timeouts, then idle time saturation
    idle_pct = 15;
    apply_settings(8'd36, 8'd36, 8'd255, 8'd255);
    random_traffic(14);
    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    repeat (258) send_item(OP_TICK, 8'($urandom_range(0, 255)));

    // Oversized length_max leaves LEN_LIMIT as the hard limit; fastest timeouts
    idle_pct = 40;
    apply_settings(8'd0, 8'h3F, 8'd1, 8'd1);
    random_traffic(20);

    // Mid-range window, with a full drain in the middle
    idle_pct = 20;
    apply_settings(8'd5, 8'd20, 8'd3, 8'd2);
    random_traffic(14);
    settle_block();
    random_traffic(10);
    idle_pct = 0;
    random_traffic(16);

    settle_block();
    $display("Sent %0d input transactions over %0d register settings", items_sent,
             settings_used);
    $display("Checked %0d frame bytes and %0d status reports (%0d good, %0d bad frames)",
             sb.byte_results, sb.status_results, sb.good_frames, sb.crc_errors);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
